// ===== sv/cpsm_pkg.sv =====
// Package: opcodes, register indexes and helper functions for the controller port block.
`default_nettype none
package cpsm_pkg;
  typedef enum logic [2:0] {
    OP_SET_PAD   = 3'd0,
    OP_MOTION    = 3'd1,
    OP_WRITE_IO  = 3'd2,
    OP_READ_IO   = 3'd3,
    OP_STROBE    = 3'd4,
    OP_SERIAL    = 3'd5,
    OP_AUTO_READ = 3'd6,
    OP_AUTO_REG  = 3'd7
  } opcode_t;

  localparam logic [1:0] REG_TAP       = 2'd0;
  localparam logic [1:0] REG_MOUSE     = 2'd1;
  localparam logic [1:0] REG_CONNECTED = 2'd2;

  localparam int ITEM_W = 48;
  localparam int RES_W  = 9;

  function automatic logic [7:0] clamp127(input logic signed [9:0] v);
    if (v > 10'sd127) clamp127 = 8'sd127;
    else if (v < -10'sd127) clamp127 = -8'sd127;
    else clamp127 = v[7:0];
  endfunction

  function automatic logic [15:0] rev16(input logic [15:0] s);
    for (int i = 0; i < 16; i++) rev16[i] = s[15-i];
  endfunction

  // |v|*(2+speed)/2 with truncation, sign restored, clamped
  function automatic logic [7:0] scale_axis(input logic [7:0] v, input logic [1:0] spd);
    logic [7:0]  a;
    logic [9:0]  m;
    logic [8:0]  h;
    a = v[7] ? (~v + 8'd1) : v;
    m = {2'b00, a} * ({8'd0, 2'd2} + {8'd0, spd});
    h = m[9:1];
    if (h > 9'd127) h = 9'd127;
    scale_axis = v[7] ? (~h[7:0] + 8'd1) : h[7:0];
  endfunction
endpackage
`default_nettype wire

// ===== sv/controller_port_serial_multitap_mouse.sv =====
// Top level: two controller ports with multitaps and serial mice behind a stream port.
// Each item passes through an input register that holds it, one layer of shallow logic
// that updates the state and forms the result, and a result register with a skid
// stage that holds the result. One item per cycle is sustained while out_tready stays high;
// the rate is set by the single state-update pass from input register to state.
`default_nettype none
module controller_port_serial_multitap_mouse #(
  parameter int SEATS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // opcode[2:0] port[3] seat[6:4] buttons[18:7] delta_x[26:19] delta_y[34:27]
  // left_button[35] right_button[36] write_value[44:37] reg_offset[47:45]
  input  wire logic [cpsm_pkg::ITEM_W-1:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // read_data[7:0] accepted[8], zero filled to 16 bits
  output logic [15:0]      out_tdata,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import cpsm_pkg::*;
  localparam int SW = $clog2(SEATS);

  // config
  logic [1:0] tap_r, mmask_r;
  logic [7:0] conn_r;
  // state
  logic [11:0] live_r [SEATS];
  logic [11:0] lat_r  [SEATS];
  logic [1:0]  bank_r;
  logic [7:0]  sidx_r [4];
  logic        strobe_r;
  logic [15:0] aw_r   [4];
  logic        aready_r;
  logic [7:0]  px_r [2], py_r [2], sx_r [2], sy_r [2];
  logic [1:0]  pb_r [2], sb_r [2];   // [0]=left [1]=right
  logic [5:0]  mpos_r [2];
  logic [1:0]  spd_r  [2];

  // input register
  logic                v_r;
  logic [ITEM_W-1:0]   it_r;
  // output + skid
  logic                ov_r, sv_r;
  logic [RES_W-1:0]    od_r, sd_r;

  assign cfg_pready = 1'b1;
  wire cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;
  always_comb begin
    case (cfg_paddr[3:2])
      REG_TAP:       cfg_prdata = {30'd0, tap_r};
      REG_MOUSE:     cfg_prdata = {30'd0, mmask_r};
      REG_CONNECTED: cfg_prdata = {24'd0, conn_r};
      default:       cfg_prdata = 32'd0;
    endcase
  end

  assign in_tready = rst_n && !sv_r;
  wire take = v_r && !sv_r;  // staged item moves on when the skid is empty

  opcode_t     op;
  logic        prt;
  logic [2:0]  seat;
  logic [11:0] btn;
  logic [7:0]  dx, dy, wv;
  logic        lb, rb;
  logic [2:0]  roff;
  assign op   = opcode_t'(it_r[2:0]);
  assign prt  = it_r[3];
  assign seat = it_r[6:4];
  assign btn  = it_r[18:7];
  assign dx   = it_r[26:19];
  assign dy   = it_r[34:27];
  assign lb   = it_r[35];
  assign rb   = it_r[36];
  assign wv   = it_r[44:37];
  assign roff = it_r[47:45];

  wire [1:0] mon = mmask_r & ~tap_r;

  function automatic logic mbit(input logic [7:0] x, input logic [7:0] y,
                                input logic [1:0] b, input logic [1:0] s,
                                input logic [5:0] i);
    logic [7:0] ax, ay;
    ax = x[7] ? (~x + 8'd1) : x;
    ay = y[7] ? (~y + 8'd1) : y;
    if (i < 6'd8) mbit = 1'b0;
    else if (i == 6'd8) mbit = b[1];
    else if (i == 6'd9) mbit = b[0];
    else if (i == 6'd10) mbit = s[1];
    else if (i == 6'd11) mbit = s[0];
    else if (i < 6'd15) mbit = 1'b0;
    else if (i == 6'd15) mbit = 1'b1;
    else if (i == 6'd16) mbit = y[7];
    else if (i <= 6'd23) mbit = ay[3'(6'd23 - i)];
    else if (i == 6'd24) mbit = x[7];
    else if (i <= 6'd31) mbit = ax[3'(6'd31 - i)];
    else mbit = 1'b0;
  endfunction

  function automatic logic [15:0] prefix_word(input logic [1:0] b, input logic [1:0] s);
    // bit i of stream at bit 15-i
    prefix_word = {8'd0, b[1], b[0], s[1], s[0], 3'b000, 1'b1};
  endfunction

  // seat lookup; returns valid flag
  function automatic logic [SW:0] seat_of(input logic p, input logic line,
                                          input logic [1:0] tm, input logic [1:0] bs);
    logic bk;
    logic [2:0] base;
    bk = ~bs[p];
    base = !p ? 3'd0 : (tm[0] ? 3'd4 : 3'd1);
    if (!tm[p]) begin
      if (line) seat_of = '0;
      else if (tm[0] && p) seat_of = {1'b1, SW'(3'd4)};
      else seat_of = {1'b1, SW'({2'd0, p})};
    end else begin
      seat_of = {1'b1, SW'(base + {1'b0, bk, 1'b0} + {2'd0, line})};
    end
  endfunction

  logic [RES_W-1:0] res;
  always_comb begin
    logic [SW:0] s0, s1;
    logic        bk, d0, d1;
    logic [1:0]  ix;
    logic [15:0] w;
    logic [2:0]  slot;
    bk = tap_r[prt] ? ~bank_r[prt] : 1'b0;
    ix = {prt, bk};
    s0 = seat_of(prt, 1'b0, tap_r, bank_r);
    s1 = seat_of(prt, 1'b1, tap_r, bank_r);
    d0 = 1'b0; d1 = 1'b0; w = '0; slot = '0;
    res = '0;
    case (op)
      OP_MOTION: res[8] = mon[prt];
      OP_READ_IO: res[7:0] = {bank_r[1], bank_r[0], 6'd0};
      OP_SERIAL: begin
        if (mon[prt]) begin
          if (strobe_r) res[0] = 1'b0;
          else if (mpos_r[prt] < 6'd32)
            res[0] = mbit(sx_r[prt], sy_r[prt], sb_r[prt], spd_r[prt], mpos_r[prt]);
          else res[0] = 1'b1;
        end else begin
          if (s0[SW]) begin
            if (strobe_r) d0 = tap_r[prt] ? 1'b0 : live_r[s0[SW-1:0]][0];
            else if (sidx_r[ix] < 8'd16)
              d0 = (sidx_r[ix] < 8'd12) ? lat_r[s0[SW-1:0]][sidx_r[ix][3:0]] : 1'b0;
            else if (sidx_r[ix] == 8'd16 && tap_r[prt]) d0 = conn_r[s0[SW-1:0]];
            else d0 = 1'b1;
          end
          if (s1[SW]) begin
            if (strobe_r) d1 = 1'b1;
            else if (sidx_r[ix] < 8'd16)
              d1 = (sidx_r[ix] < 8'd12) ? lat_r[s1[SW-1:0]][sidx_r[ix][3:0]] : 1'b0;
            else if (sidx_r[ix] == 8'd16) d1 = conn_r[s1[SW-1:0]];
            else d1 = 1'b1;
          end
          res[1:0] = {d1, d0};
        end
      end
      OP_AUTO_REG: begin
        slot = {1'b0, roff[2:1]};
        if (tap_r == 2'b00) begin
          if (slot == 3'd0) w = rev16({4'd0, live_r[0]});
          else if (slot == 3'd1)
            w = mon[1] ? prefix_word(sb_r[1], spd_r[1])
                       : rev16({4'd0, live_r[1]});
          else w = '0;
        end else w = aready_r ? aw_r[slot[1:0]] : '0;
        res[7:0] = roff[0] ? w[15:8] : w[7:0];
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    logic [1:0] on_prev, on_next, rise;
    logic [SW:0] st;
    logic bk;
    if (!rst_n) begin
      tap_r <= '0; mmask_r <= '0; conn_r <= 8'hff;
      for (int i = 0; i < SEATS; i++) begin live_r[i] <= '0; lat_r[i] <= '0; end
      bank_r <= '0; strobe_r <= 1'b0; aready_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin sidx_r[i] <= '0; aw_r[i] <= '0; end
      for (int p = 0; p < 2; p++) begin
        px_r[p] <= '0; py_r[p] <= '0; sx_r[p] <= '0; sy_r[p] <= '0;
        pb_r[p] <= '0; sb_r[p] <= '0; mpos_r[p] <= '0; spd_r[p] <= '0;
      end
      v_r <= 1'b0; ov_r <= 1'b0; sv_r <= 1'b0;
    end else begin
      // config write: plugging a mouse clears that port's mouse state
      if (cfg_wr) begin
        on_prev = mon;
        on_next = mon;
        case (cfg_paddr[3:2])
          REG_TAP:       begin
            tap_r <= cfg_pwdata[1:0]; on_next = mmask_r & ~cfg_pwdata[1:0];
          end
          REG_MOUSE:     begin
            mmask_r <= cfg_pwdata[1:0]; on_next = cfg_pwdata[1:0] & ~tap_r;
          end
          REG_CONNECTED: conn_r <= cfg_pwdata[7:0];
          default: ;
        endcase
        rise = on_next & ~on_prev;
        for (int p = 0; p < 2; p++) if (rise[p]) begin
          px_r[p] <= '0; py_r[p] <= '0; pb_r[p] <= '0;
          sx_r[p] <= '0; sy_r[p] <= '0; mpos_r[p] <= '0; spd_r[p] <= '0;
        end
      end

      if (take) begin
        case (op)
          OP_SET_PAD: live_r[seat[SW-1:0]] <= btn;
          OP_MOTION: if (mon[prt]) begin
            px_r[prt] <= clamp127({{2{px_r[prt][7]}}, px_r[prt]} + {{2{dx[7]}}, dx});
            py_r[prt] <= clamp127({{2{py_r[prt][7]}}, py_r[prt]} + {{2{dy[7]}}, dy});
            pb_r[prt] <= {rb, lb};
          end
          OP_WRITE_IO: bank_r <= wv[7:6];
          OP_STROBE: begin
            if (wv[0] || strobe_r) begin
              for (int i = 0; i < SEATS; i++) lat_r[i] <= live_r[i];
              for (int i = 0; i < 4; i++) sidx_r[i] <= '0;
              for (int p = 0; p < 2; p++) if (mon[p]) begin
                mpos_r[p] <= '0;
                if (!wv[0]) begin
                  sx_r[p] <= scale_axis(px_r[p], spd_r[p]);
                  sy_r[p] <= scale_axis(py_r[p], spd_r[p]);
                  sb_r[p] <= pb_r[p];
                  px_r[p] <= '0; py_r[p] <= '0; pb_r[p] <= '0;
                end
              end
            end
            strobe_r <= wv[0];
          end
          OP_SERIAL: begin
            if (mon[prt]) begin
              if (strobe_r) spd_r[prt] <= (spd_r[prt] == 2'd2) ? 2'd0 : spd_r[prt] + 2'd1;
              else if (mpos_r[prt] < 6'd32) mpos_r[prt] <= mpos_r[prt] + 6'd1;
            end else begin
              bk = tap_r[prt] ? ~bank_r[prt] : 1'b0;
              if (!strobe_r && sidx_r[{prt, bk}] != 8'd255)
                sidx_r[{prt, bk}] <= sidx_r[{prt, bk}] + 8'd1;
            end
          end
          OP_AUTO_READ: begin
            for (int i = 0; i < SEATS; i++) lat_r[i] <= live_r[i];
            // the active bank of each port reads 16 shifted bits, the other restarts
            for (int i = 0; i < 4; i++)
              sidx_r[i] <= (i[0] == (tap_r[i[1]] ? ~bank_r[i[1]] : 1'b0)) ? 8'd16 : 8'd0;
            for (int p = 0; p < 2; p++) begin
              if (mon[p]) mpos_r[p] <= '0;
              for (int l = 0; l < 2; l++) begin
                st = seat_of(p[0], l[0], tap_r, bank_r);
                if (mon[p])
                  aw_r[l*2+p] <= (l == 0) ? prefix_word(sb_r[p], spd_r[p]) : '0;
                else
                  aw_r[l*2+p] <= st[SW] ? rev16({4'd0, live_r[st[SW-1:0]]}) : '0;
              end
            end
            aready_r <= 1'b1;
          end
          default: ;
        endcase
      end

      // input register
      if (in_tvalid && in_tready) v_r <= 1'b1;
      else if (take) v_r <= 1'b0;
      // output register with skid
      if (take) begin
        if (ov_r && !out_tready) sv_r <= 1'b1;
        else ov_r <= 1'b1;
      end else if (out_tready) begin
        if (sv_r) sv_r <= 1'b0;
        else ov_r <= 1'b0;
      end
    end
    if (in_tvalid && in_tready) it_r <= in_tdata;
    if (take) begin
      if (ov_r && !out_tready) sd_r <= res;
      else od_r <= res;
    end else if (out_tready && sv_r) od_r <= sd_r;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {7'd0, od_r};

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n) sv_r |-> ov_r)
    else $error("skid holds item while output empty");
  a_no_take_full: assert property (@(posedge clk) disable iff (!rst_n) sv_r |-> !in_tready)
    else $error("input open while skid full");
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mpos_r[0] <= 6'd32 && mpos_r[1] <= 6'd32)
    else $error("mouse bit position beyond stream");
endmodule
`default_nettype wire
